### rtl/ibcs_pkg.sv
// Shared constants and types for the IMU bias calibration and smoothing block.
// Holds register widths, reset values, register indexes and the lane control struct.
// No dependencies.
package ibcs_pkg;

  localparam int CALIB_W     = 13;
  localparam int DEADBAND_W  = 10;
  localparam int GRAVITY_W   = 15;
  localparam int CFG_DATA_W  = 15;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CALIB_W-1:0]    CALIB_RESET    = 13'd500;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 10'd10;
  localparam logic [GRAVITY_W-1:0]  GRAVITY_RESET  = 15'd9810;

  // The smoothing step is one tenth of the distance to the new rate.
  localparam int FILTER_DIV = 10;

  localparam int NUM_AXES  = 3;
  localparam int NUM_LANES = 2 * NUM_AXES;
  localparam int AXIS_Y    = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CALIB_SAMPLES = 2'd0,
    REG_GYRO_DEADBAND = 2'd1,
    REG_GRAVITY_LEVEL = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic acc;
    logic clr;
    logic start;
  } lane_ctrl_t;

endpackage

### rtl/ibcs_sdiv.sv
// Bit-serial signed divider with truncation toward zero, one quotient bit per cycle.
// Used inside each lane; no package dependencies.
module ibcs_sdiv #(
  parameter int DW = 33,
  parameter int VW = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW:0]   dividend,
  input  logic        [VW-1:0] divisor,
  output logic                 done,
  output logic signed [DW:0]   quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [VW-1:0] dsor;
  logic [DW-1:0] qsr;
  logic          neg;
  logic [VW:0]   shifted;
  logic [VW:0]   trial;
  logic [DW:0]   mag_in;
  logic [DW:0]   qext;

  assign mag_in  = dividend[DW] ? (~dividend + 1'b1) : dividend;
  assign shifted = {rem, qsr[DW-1]};
  assign trial   = shifted - {1'b0, dsor};
  assign qext    = {1'b0, qsr};
  assign quotient = neg ? $signed(~qext + 1'b1) : $signed(qext);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[DW];
      rem  <= '0;
      dsor <= divisor;
      qsr  <= mag_in[DW-1:0];
    end else if (busy) begin
      rem <= trial[VW] ? shifted[VW-1:0] : trial[VW-1:0];
      qsr <= {qsr[DW-2:0], ~trial[VW]};
    end
  end

endmodule

### rtl/ibcs_lane.sv
// One axis lane: calibration accumulator plus a serial divider.
// Depends on ibcs_pkg for the control struct and on ibcs_sdiv.
module ibcs_lane
  import ibcs_pkg::*;
#(
  parameter int SB   = 20,
  parameter int SUMW = 33,
  parameter int DW   = 33,
  parameter int VW   = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lane_ctrl_t           ctrl,
  input  logic signed [SB-1:0] sample,
  input  logic        [VW-1:0] divisor,
  output logic                 done,
  output logic signed [DW:0]   quotient
);

  logic signed [SUMW-1:0] sum;
  logic signed [DW:0]     dividend;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      sum <= '0;
    end else if (ctrl.acc) begin
      sum <= sum + SUMW'(sample);
    end
  end

  assign dividend = (DW + 1)'(sum);

  ibcs_sdiv #(
    .DW(DW),
    .VW(VW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (ctrl.start),
    .dividend(dividend),
    .divisor (divisor),
    .done    (done),
    .quotient(quotient)
  );

endmodule

### rtl/imu_bias_calibrate_and_smooth.sv
// Six-lane IMU bias calibration and gyro smoothing. A calibration sample that does not close
// a run goes through the check and output states; for a measurement sample the one-tenth
// filter step is a shift-and-add reciprocal estimate with a remainder fix-up, spread over
// three registered stages. A sample that closes a run waits in the divide state for the
// bit-serial divider in each lane, which forms the averages over DW quotient bits, where
// DW = max(SAMPLE_BITS + clog2(MAX_CALIB + 1), SAMPLE_BITS + FILTER_FRAC + 2). One item is
// worked on at a time, and the next beat is taken while a result still waits in the output
// register; a stalled result holds the next item in its last state until the output
// register drains.
module imu_bias_calibrate_and_smooth
  import ibcs_pkg::*;
#(
  parameter int SAMPLE_BITS = 20,
  parameter int FILTER_FRAC = 8,
  parameter int MAX_CALIB   = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic signed [SAMPLE_BITS-1:0] gyro_x,
  input  logic signed [SAMPLE_BITS-1:0] gyro_y,
  input  logic signed [SAMPLE_BITS-1:0] gyro_z,
  input  logic signed [SAMPLE_BITS-1:0] acc_x,
  input  logic signed [SAMPLE_BITS-1:0] acc_y,
  input  logic signed [SAMPLE_BITS-1:0] acc_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] rate_x_smooth,
  output logic signed [SAMPLE_BITS-1:0] rate_y_smooth,
  output logic signed [SAMPLE_BITS-1:0] rate_z_smooth,
  output logic signed [SAMPLE_BITS-1:0] accel_x_fixed,
  output logic signed [SAMPLE_BITS-1:0] accel_y_fixed,
  output logic signed [SAMPLE_BITS-1:0] accel_z_fixed,
  output logic                          calibrating,
  output logic                          offsets_ready
);

  localparam int SB   = SAMPLE_BITS;
  localparam int CNTW = $clog2(MAX_CALIB + 1);
  localparam int TW   = (CNTW > CALIB_W) ? CNTW : CALIB_W;
  localparam int FW   = SAMPLE_BITS + FILTER_FRAC;
  localparam int SUMW = SAMPLE_BITS + CNTW;
  localparam int DW   = (SUMW > FW + 2) ? SUMW : FW + 2;
  localparam int XW   = DW + 2;

  localparam logic signed [XW-1:0] SB_MAX = {{(XW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
  localparam logic signed [XW-1:0] SB_MIN = ~SB_MAX;
  localparam logic signed [XW-1:0] FW_MAX = {{(XW - FW + 1){1'b0}}, {(FW - 1){1'b1}}};
  localparam logic signed [XW-1:0] FW_MIN = ~FW_MAX;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PREP,
    S_STEP1,
    S_STEP2,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  function automatic logic signed [SB-1:0] sat_sb(input logic signed [XW-1:0] v);
    logic signed [SB-1:0] r;
    if (v > SB_MAX) begin
      r = SB_MAX[SB-1:0];
    end else if (v < SB_MIN) begin
      r = SB_MIN[SB-1:0];
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [FW-1:0] sat_fw(input logic signed [XW-1:0] v);
    logic signed [FW-1:0] r;
    if (v > FW_MAX) begin
      r = FW_MAX[FW-1:0];
    end else if (v < FW_MIN) begin
      r = FW_MIN[FW-1:0];
    end else begin
      r = v[FW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SB-1:0] filt_int(input logic signed [FW-1:0] y);
    logic signed [SB-1:0] r;
    r = y[FW-1:FILTER_FRAC];
    if (y[FW-1] && (|y[FILTER_FRAC-1:0])) begin
      r = r + SB'(1);
    end
    return r;
  endfunction

  logic [CALIB_W-1:0]    calib_samples;
  logic [DEADBAND_W-1:0] gyro_deadband;
  logic [GRAVITY_W-1:0]  gravity_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_samples <= CALIB_RESET;
      gyro_deadband <= DEADBAND_RESET;
      gravity_level <= GRAVITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CALIB_SAMPLES: calib_samples <= cfg_data[CALIB_W-1:0];
        REG_GYRO_DEADBAND: gyro_deadband <= cfg_data[DEADBAND_W-1:0];
        REG_GRAVITY_LEVEL: gravity_level <= cfg_data[GRAVITY_W-1:0];
        default: ;
      endcase
    end
  end

  state_t                state;
  logic                  func_reg;
  logic [CNTW-1:0]       count;
  logic                  done_flag;
  logic signed [SB-1:0]  s_in   [NUM_LANES];
  logic signed [SB-1:0]  s_reg  [NUM_LANES];
  logic signed [SB-1:0]  bias   [NUM_AXES];
  logic signed [SB-1:0]  offs   [NUM_AXES];
  logic signed [FW-1:0]  filt   [NUM_AXES];
  logic        [DW:0]    mag_reg   [NUM_AXES];
  logic        [DW:0]    tenth_reg [NUM_AXES];
  logic signed [DW:0]    step_reg  [NUM_AXES];
  logic [NUM_AXES-1:0]   neg_reg;
  logic [NUM_AXES-1:0]   upd_reg;
  logic        [DW:0]    mag_ax    [NUM_AXES];
  logic        [DW:0]    tenth_ax  [NUM_AXES];
  logic signed [DW:0]    step_ax   [NUM_AXES];
  logic [NUM_AXES-1:0]   neg_ax;
  logic [NUM_AXES-1:0]   upd_ax;
  logic signed [DW:0]    quot   [NUM_LANES];
  logic [NUM_LANES-1:0]  lane_done;
  logic [CNTW-1:0]       lane_divisor;
  lane_ctrl_t            lane_ctrl;
  logic [TW-1:0]         calib_ext;
  logic [TW-1:0]         target;
  logic                  calib_hit;
  logic                  in_accept;
  logic                  out_free;

  assign s_in[0] = gyro_x;
  assign s_in[1] = gyro_y;
  assign s_in[2] = gyro_z;
  assign s_in[3] = acc_x;
  assign s_in[4] = acc_y;
  assign s_in[5] = acc_z;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    calib_ext = TW'(calib_samples);
    if (calib_ext == '0) begin
      target = TW'(1);
    end else if (calib_ext > TW'(MAX_CALIB)) begin
      target = TW'(MAX_CALIB);
    end else begin
      target = calib_ext;
    end
    calib_hit = TW'(count) >= target;
  end

  // The filter step magnitude is estimated as 0.8 * |diff| / 8 by shifts and adds, which
  // never overshoots, and the remainder then raises the estimate to the exact quotient.
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
    logic signed [SB:0] d;
    logic        [SB:0] mag;
    logic signed [DW:0] diff;
    logic        [DW:0] q_est;
    logic        [DW+4:0] rem;
    logic        [DW:0] q_fix;

    assign d   = (SB + 1)'(s_reg[g]) - (SB + 1)'(bias[g]);
    assign mag = d[SB] ? (~d + 1'b1) : d;
    assign upd_ax[g] = mag > (SB + 1)'(gyro_deadband);
    assign diff      = ((DW + 1)'(d) <<< FILTER_FRAC) - (DW + 1)'(filt[g]);
    assign neg_ax[g] = diff[DW];
    assign mag_ax[g] = diff[DW] ? (~diff + 1'b1) : diff;

    always_comb begin
      q_est = (mag_reg[g] >> 1) + (mag_reg[g] >> 2);
      for (int s = 4; s < DW + 1; s = s * 2) begin
        q_est = q_est + (q_est >> s);
      end
    end

    assign tenth_ax[g] = q_est >> 3;
    assign rem   = (DW + 5)'(mag_reg[g]) - (DW + 5)'(tenth_reg[g]) * (DW + 5)'(FILTER_DIV);
    assign q_fix = (rem >= (DW + 5)'(2 * FILTER_DIV)) ? tenth_reg[g] + (DW + 1)'(2) :
                   (rem >= (DW + 5)'(FILTER_DIV))     ? tenth_reg[g] + (DW + 1)'(1) :
                                                        tenth_reg[g];
    assign step_ax[g] = neg_reg[g] ? $signed(~q_fix + 1'b1) : $signed(q_fix);
  end

  always_comb begin
    lane_ctrl.acc   = in_accept && !func;
    lane_ctrl.clr   = (state == S_FIN) && !func_reg;
    lane_ctrl.start = (state == S_CHECK) && calib_hit;
    lane_divisor    = count;
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    ibcs_lane #(
      .SB  (SB),
      .SUMW(SUMW),
      .DW  (DW),
      .VW  (CNTW)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (lane_ctrl),
      .sample  (s_in[l]),
      .divisor (lane_divisor),
      .done    (lane_done[l]),
      .quotient(quot[l])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      done_flag <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        bias[a] <= '0;
        offs[a] <= '0;
        filt[a] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            func_reg <= func;
            for (int l = 0; l < NUM_LANES; l++) begin
              s_reg[l] <= s_in[l];
            end
            if (!func) begin
              count <= count + 1'b1;
              state <= S_CHECK;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_CHECK: begin
          state <= calib_hit ? S_DIV : S_OUT;
        end
        S_PREP: begin
          for (int a = 0; a < NUM_AXES; a++) begin
            mag_reg[a] <= mag_ax[a];
          end
          neg_reg <= neg_ax;
          upd_reg <= upd_ax;
          state   <= S_STEP1;
        end
        S_STEP1: begin
          for (int a = 0; a < NUM_AXES; a++) begin
            tenth_reg[a] <= tenth_ax[a];
          end
          state <= S_STEP2;
        end
        S_STEP2: begin
          for (int a = 0; a < NUM_AXES; a++) begin
            step_reg[a] <= step_ax[a];
          end
          state <= S_FIN;
        end
        S_DIV: begin
          if (&lane_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!func_reg) begin
            for (int a = 0; a < NUM_AXES; a++) begin
              bias[a] <= sat_sb(XW'(quot[a]));
              if (a == AXIS_Y) begin
                offs[a] <= sat_sb(XW'(quot[a + NUM_AXES])
                                  - XW'($signed({1'b0, gravity_level})));
              end else begin
                offs[a] <= sat_sb(XW'(quot[a + NUM_AXES]));
              end
            end
            count     <= '0;
            done_flag <= 1'b1;
          end else begin
            for (int a = 0; a < NUM_AXES; a++) begin
              if (upd_reg[a]) begin
                filt[a] <= sat_fw(XW'(filt[a]) + XW'(step_reg[a]));
              end
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            calibrating   <= !func_reg;
            offsets_ready <= done_flag;
            if (!func_reg) begin
              rate_x_smooth <= '0;
              rate_y_smooth <= '0;
              rate_z_smooth <= '0;
              accel_x_fixed <= '0;
              accel_y_fixed <= '0;
              accel_z_fixed <= '0;
            end else begin
              rate_x_smooth <= filt_int(filt[0]);
              rate_y_smooth <= filt_int(filt[1]);
              rate_z_smooth <= filt_int(filt[2]);
              accel_x_fixed <= sat_sb(XW'(s_reg[3]) - XW'(offs[0]));
              accel_y_fixed <= sat_sb(XW'(s_reg[4]) - XW'(offs[1]));
              accel_z_fixed <= sat_sb(XW'(s_reg[5]) - XW'(offs[2]));
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A calibration beat never carries rate or acceleration data.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && calibrating) |-> (rate_x_smooth == '0 && rate_y_smooth == '0 &&
      rate_z_smooth == '0 && accel_x_fixed == '0 && accel_y_fixed == '0 &&
      accel_z_fixed == '0))
    else $error("calibration result carries nonzero data");

  // All lane dividers run in lockstep.
  assert property (@(posedge clk) disable iff (rst) (|lane_done) |-> (&lane_done))
    else $error("lane dividers out of step");

  // Closing a calibration run clears the count and marks the offsets ready.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !func_reg) |=> (done_flag && count == '0))
    else $error("calibration close did not update state");

  // The sample count never runs past the largest run length.
  assert property (@(posedge clk) disable iff (rst) TW'(count) <= TW'(MAX_CALIB))
    else $error("calibration count overflow");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for imu_bias_calibrate_and_smooth: directed and random sample beats are
// checked against an in-bench model of the calibration sums, offsets and gyro filters.
// Depends on ibcs_pkg and the block's RTL only.
module tb_top;
  import ibcs_pkg::*;

  localparam int SB = 20;
  localparam int FRAC = 8;
  localparam int FB = SB + FRAC;
  localparam longint MAX_COUNT = 4096;
  localparam longint SMP_MAX = 524287;
  localparam longint SMP_MIN = -524288;
  localparam logic FUNC_CALIB = 1'b0;
  localparam logic FUNC_MEASURE = 1'b1;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BEATS = 50;
  localparam int LONG_RUN_BEATS = 40;

  typedef logic [5:0][SB-1:0] frame_t;

  typedef struct packed {
    logic [SB-1:0] rate_x;
    logic [SB-1:0] rate_y;
    logic [SB-1:0] rate_z;
    logic [SB-1:0] accel_x;
    logic [SB-1:0] accel_y;
    logic [SB-1:0] accel_z;
    logic          calibrating;
    logic          ready;
  } imu_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = FUNC_MEASURE;
  logic signed [SB-1:0] gyro_x = '0;
  logic signed [SB-1:0] gyro_y = '0;
  logic signed [SB-1:0] gyro_z = '0;
  logic signed [SB-1:0] acc_x = '0;
  logic signed [SB-1:0] acc_y = '0;
  logic signed [SB-1:0] acc_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SB-1:0] rate_x_smooth;
  logic signed [SB-1:0] rate_y_smooth;
  logic signed [SB-1:0] rate_z_smooth;
  logic signed [SB-1:0] accel_x_fixed;
  logic signed [SB-1:0] accel_y_fixed;
  logic signed [SB-1:0] accel_z_fixed;
  logic calibrating;
  logic offsets_ready;

  // Model state, mirroring the block after reset.
  logic [CALIB_W-1:0] calib_target_reg = CALIB_RESET;
  logic [DEADBAND_W-1:0] deadband_reg = DEADBAND_RESET;
  logic [GRAVITY_W-1:0] gravity_reg = GRAVITY_RESET;
  longint rate_filt [3] = '{0, 0, 0};
  longint rate_bias [3] = '{0, 0, 0};
  longint acc_offset [3] = '{0, 0, 0};
  longint calib_acc [6] = '{0, 0, 0, 0, 0, 0};
  longint calib_seen = 0;
  logic offsets_done = 1'b0;

  imu_result_t pending_results [$];
  int mismatches = 0;
  int cycles = 0;
  logic quiet = 1'b0;

  imu_bias_calibrate_and_smooth i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
    .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .rate_x_smooth(rate_x_smooth), .rate_y_smooth(rate_y_smooth),
    .rate_z_smooth(rate_z_smooth), .accel_x_fixed(accel_x_fixed),
    .accel_y_fixed(accel_y_fixed), .accel_z_fixed(accel_z_fixed),
    .calibrating(calibrating), .offsets_ready(offsets_ready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic longint clamp(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic imu_result_t imu_response(logic f, frame_t fr);
    imu_result_t r;
    longint target;
    longint d;
    longint mag;
    longint diff;
    longint one;
    longint rate [3];
    longint accel [3];
    r = '0;
    one = longint'(1) << FRAC;
    if (f == FUNC_CALIB) begin
      target = longint'(calib_target_reg);
      if (target == 0) target = 1;
      if (target > MAX_COUNT) target = MAX_COUNT;
      for (int k = 0; k < 6; k++) calib_acc[k] += longint'($signed(fr[k]));
      calib_seen++;
      if (calib_seen >= target) begin
        for (int k = 0; k < 3; k++) begin
          rate_bias[k] = clamp(calib_acc[k] / calib_seen, SB);
          acc_offset[k] = calib_acc[k + 3] / calib_seen;
        end
        acc_offset[AXIS_Y] -= longint'(gravity_reg);
        for (int k = 0; k < 3; k++) acc_offset[k] = clamp(acc_offset[k], SB);
        for (int k = 0; k < 6; k++) calib_acc[k] = 0;
        calib_seen = 0;
        offsets_done = 1'b1;
      end
      r.calibrating = 1'b1;
    end else begin
      for (int k = 0; k < 3; k++) begin
        d = longint'($signed(fr[k])) - rate_bias[k];
        mag = (d < 0) ? -d : d;
        if (mag > longint'(deadband_reg)) begin
          diff = d * one - rate_filt[k];
          rate_filt[k] = clamp(rate_filt[k] + diff / FILTER_DIV, FB);
        end
        rate[k] = clamp(rate_filt[k] / one, SB);
        accel[k] = clamp(longint'($signed(fr[k + 3])) - acc_offset[k], SB);
      end
      r.rate_x = SB'(rate[0]);
      r.rate_y = SB'(rate[1]);
      r.rate_z = SB'(rate[2]);
      r.accel_x = SB'(accel[0]);
      r.accel_y = SB'(accel[1]);
      r.accel_z = SB'(accel[2]);
    end
    r.ready = offsets_done;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [SB-1:0] want, logic [SB-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, $signed(want), $signed(got));
  endtask

  task automatic check_beat(imu_result_t want);
    if (rate_x_smooth !== want.rate_x) flag_mismatch("rate_x_smooth", want.rate_x, rate_x_smooth);
    if (rate_y_smooth !== want.rate_y) flag_mismatch("rate_y_smooth", want.rate_y, rate_y_smooth);
    if (rate_z_smooth !== want.rate_z) flag_mismatch("rate_z_smooth", want.rate_z, rate_z_smooth);
    if (accel_x_fixed !== want.accel_x) flag_mismatch("accel_x_fixed", want.accel_x, accel_x_fixed);
    if (accel_y_fixed !== want.accel_y) flag_mismatch("accel_y_fixed", want.accel_y, accel_y_fixed);
    if (accel_z_fixed !== want.accel_z) flag_mismatch("accel_z_fixed", want.accel_z, accel_z_fixed);
    if (calibrating !== want.calibrating)
      flag_mismatch("calibrating", SB'(want.calibrating), SB'(calibrating));
    if (offsets_ready !== want.ready)
      flag_mismatch("offsets_ready", SB'(want.ready), SB'(offsets_ready));
  endtask

  // Result side: check each accepted beat, then pick the stall for the next edge.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result beat with nothing expected");
        end else begin
          check_beat(pending_results.pop_front());
        end
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < 13);
    end
  end

  task automatic send_sample(logic f, frame_t fr);
    int gap;
    if (!quiet && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    gyro_x <= fr[0];
    gyro_y <= fr[1];
    gyro_z <= fr[2];
    acc_x <= fr[3];
    acc_y <= fr[4];
    acc_z <= fr[5];
    do @(posedge clk); while (in_stall);
    pending_results.push_back(imu_response(f, fr));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CALIB_SAMPLES: calib_target_reg = data[CALIB_W-1:0];
      REG_GYRO_DEADBAND: deadband_reg = data[DEADBAND_W-1:0];
      REG_GRAVITY_LEVEL: gravity_reg = data[GRAVITY_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic frame_t make_frame(longint g0, longint g1, longint g2,
                                        longint a0, longint a1, longint a2);
    frame_t fr;
    fr[0] = SB'(g0);
    fr[1] = SB'(g1);
    fr[2] = SB'(g2);
    fr[3] = SB'(a0);
    fr[4] = SB'(a1);
    fr[5] = SB'(a2);
    return fr;
  endfunction

  function automatic logic [SB-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return SB'(SMP_MAX);
      1: return SB'(SMP_MIN);
      2: return '0;
      3: return '1;
      default: return SB'(1);
    endcase
  endfunction

  function automatic frame_t random_frame();
    frame_t fr;
    for (int k = 0; k < 6; k++) fr[k] = SB'($urandom);
    return fr;
  endfunction

  task automatic test_raw_passthrough();
    send_sample(FUNC_MEASURE, make_frame(0, 0, 0, 0, 0, 0));
    send_sample(FUNC_MEASURE, make_frame(10, 11, -11, SMP_MAX, SMP_MIN, -1));
    send_sample(FUNC_MEASURE, make_frame(-10, 0, 10, 1, 0, SMP_MIN));
    send_sample(FUNC_MEASURE, make_frame(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX));
    send_sample(FUNC_MEASURE, make_frame(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN));
    send_sample(FUNC_MEASURE, make_frame(SMP_MIN, SMP_MAX, 0, 12345, -9810, 77));
  endtask

  task automatic test_single_sample_calibration();
    settle();
    write_reg(REG_CALIB_SAMPLES, 15'd0);
    send_sample(FUNC_CALIB, make_frame(100, -200, 300, 50, 9900, -40));
    send_sample(FUNC_MEASURE, make_frame(100, -200, 300, 50, 9900, -40));
    send_sample(FUNC_MEASURE, make_frame(500, -700, 1300, 0, 0, 0));
  endtask

  task automatic test_offset_saturation();
    settle();
    write_reg(REG_CALIB_SAMPLES, 15'd2);
    write_reg(REG_GRAVITY_LEVEL, 15'h7FFF);
    repeat (2) send_sample(FUNC_CALIB, make_frame(SMP_MIN, SMP_MIN, SMP_MIN,
                                                  SMP_MIN, SMP_MIN, SMP_MIN));
    send_sample(FUNC_MEASURE, make_frame(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX));
    settle();
    write_reg(REG_GRAVITY_LEVEL, 15'd0);
    repeat (2) send_sample(FUNC_CALIB, make_frame(SMP_MAX, SMP_MAX, SMP_MAX,
                                                  SMP_MAX, SMP_MAX, SMP_MAX));
    send_sample(FUNC_MEASURE, make_frame(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN));
  endtask

  task automatic test_lowered_target();
    settle();
    write_reg(REG_CALIB_SAMPLES, 15'd20);
    write_reg(REG_GRAVITY_LEVEL, GRAVITY_RESET);
    repeat (6) send_sample(FUNC_CALIB, make_frame($urandom_range(0, 400), -37, 5,
                                                  -120, 9800 + $urandom_range(0, 40), 3));
    settle();
    write_reg(REG_CALIB_SAMPLES, 15'd3);
    send_sample(FUNC_CALIB, make_frame(250, -30, 8, -100, 9830, 0));
    send_sample(FUNC_MEASURE, make_frame(900, -30, -600, 0, 9810, 0));
  endtask

  task automatic test_unused_index();
    settle();
    write_reg(REG_UNUSED, 15'h7FFF);
    send_sample(FUNC_MEASURE, random_frame());
  endtask

  task automatic test_long_calibration();
    settle();
    write_reg(REG_CALIB_SAMPLES, 15'h7FFF);
    write_reg(REG_GYRO_DEADBAND, 15'd3);
    repeat (LONG_RUN_BEATS) send_sample(FUNC_CALIB, random_frame());
    repeat (3) send_sample(FUNC_MEASURE, random_frame());
  endtask

  task automatic test_random_traffic();
    frame_t base;
    frame_t fr;
    logic f;
    int spread;
    int noise;
    int pick;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      quiet = (ph == 3);
      case (ph)
        0: begin
          write_reg(REG_CALIB_SAMPLES, 15'd1);
          write_reg(REG_GYRO_DEADBAND, 15'd0);
          write_reg(REG_GRAVITY_LEVEL, 15'd0);
        end
        1: begin
          write_reg(REG_CALIB_SAMPLES, 15'd4096);
          write_reg(REG_GYRO_DEADBAND, 15'd1000);
          write_reg(REG_GRAVITY_LEVEL, 15'h7FFF);
        end
        default: begin
          write_reg(REG_CALIB_SAMPLES, 15'($urandom_range(1, 10)) |
                    (($urandom_range(0, 3) == 0) ? 15'h6000 : 15'h0000));
          write_reg(REG_GYRO_DEADBAND, $urandom_range(0, 1) ? 15'($urandom_range(0, 60))
                                                            : 15'($urandom));
          write_reg(REG_GRAVITY_LEVEL, $urandom_range(0, 1) ? 15'($urandom)
                                                            : 15'($urandom_range(9700, 9900)));
        end
      endcase
      for (int k = 0; k < 6; k++)
        base[k] = $urandom_range(0, 1) ? SB'(int'($urandom_range(0, 6000)) - 3000)
                                       : SB'($urandom);
      base[4] = SB'(int'(gravity_reg) + int'($urandom_range(0, 200)) - 100);
      spread = 2 * int'(deadband_reg) + 20;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        f = ($urandom_range(0, 99) < 30) ? FUNC_CALIB : FUNC_MEASURE;
        for (int k = 0; k < 6; k++) begin
          pick = $urandom_range(0, 99);
          if (f == FUNC_CALIB) begin
            noise = int'($urandom_range(0, 100)) - 50;
            fr[k] = (pick < 10) ? SB'($urandom) : base[k] + SB'(noise);
          end else if (pick < 60) begin
            noise = int'($urandom_range(0, 2 * spread)) - spread;
            fr[k] = base[k] + SB'(noise);
          end else if (pick < 85) begin
            fr[k] = SB'($urandom);
          end else begin
            fr[k] = pick_extreme();
          end
        end
        send_sample(f, fr);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_raw_passthrough();
    test_single_sample_calibration();
    test_offset_saturation();
    test_lowered_target();
    test_unused_index();
    test_long_calibration();
    test_random_traffic();
    settle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
